// File: rtl/bmp24_stream_to_rgb565_core_defines.svh
// Assertion macros shared by the queue, front end and back end RTL files of the BMP to RGB565 core.
`ifndef BMP24_STREAM_TO_RGB565_CORE_DEFINES_SVH
`define BMP24_STREAM_TO_RGB565_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/bmp24_pkg.sv
package bmp24_pkg;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_IDLE
	} phase_t;

	// Result status codes.
	localparam logic [1:0] ST_PIXEL     = 2'd0;
	localparam logic [1:0] ST_BAD_SIG   = 2'd1;
	localparam logic [1:0] ST_BAD_DEPTH = 2'd2;
	localparam logic [1:0] ST_BAD_RANGE = 2'd3;

	// Header byte positions.
	localparam int          POS_W    = 5;
	localparam logic [4:0]  POS_SIG0 = 5'd0;
	localparam logic [4:0]  POS_SIG1 = 5'd1;
	localparam logic [4:0]  POS_OFS  = 5'd10;
	localparam logic [4:0]  POS_OFS3 = 5'd13;
	localparam logic [4:0]  POS_WID  = 5'd18;
	localparam logic [4:0]  POS_HGT  = 5'd22;
	localparam logic [4:0]  POS_BPP0 = 5'd28;
	localparam logic [4:0]  POS_BPP1 = 5'd29;

	localparam logic [7:0]  SIG_B      = 8'h42;
	localparam logic [7:0]  SIG_M      = 8'h4D;
	localparam logic [15:0] BPP_24     = 16'd24;
	localparam int          MIN_OFFSET = 30;
	localparam int          ROW_ALIGN  = 4;

	localparam int QUEUE_DEPTH = 4;

	// One result on its way from the parser to the output stage.
	typedef struct packed {
		logic [1:0] status;
		logic       last;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rec_t;

endpackage

// File: rtl/bmp24_queue.sv
`include "bmp24_stream_to_rgb565_core_defines.svh"

module bmp24_queue #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`ASSERT_IMP(a_no_overrun, clk, arst_n, push, !full)
	`ASSERT_IMP(a_no_underrun, clk, arst_n, pop, !empty)

endmodule

// File: rtl/bmp24_front.sv
`include "bmp24_stream_to_rgb565_core_defines.svh"

module bmp24_front
	import bmp24_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       file_start,
	input  logic       q_full,
	output logic       push,
	output rec_t       rec
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int ROW_W = $clog2(3 * MAX_DIM + 4);

	localparam logic [1:0] LANE_BLUE  = 2'd0;
	localparam logic [1:0] LANE_GREEN = 2'd1;
	localparam logic [1:0] LANE_RED   = 2'd2;

	phase_t            phase_q, phase_d, eff_phase;
	logic [POS_W-1:0]  pos_q, eff_pos;
	logic [31:0]       ofs_q, wid_q, hgt_q;
	logic [7:0]        bpp_lo_q, blue_q, green_q;
	logic [ROW_W-1:0]  dlm1_q, rlm1_q, rbc_q, dlen, rlen;
	logic [DIM_W-1:0]  hm1_q, row_q;
	logic [1:0]        lane_q, cap_lane;
	logic              accept, in_data, fin, size_bad, err;
	logic [1:0]        err_code;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// A file start restarts the parse with the very byte that carries it.
	assign eff_phase = file_start ? PH_HEADER : phase_q;
	assign eff_pos   = file_start ? '0 : pos_q;
	assign cap_lane  = 2'(eff_pos - POS_OFS);

	assign size_bad = (wid_q == '0) || (hgt_q == '0) ||
		(wid_q > 32'(MAX_DIM)) || (hgt_q > 32'(MAX_DIM));

	assign dlen = ROW_W'(wid_q[DIM_W-1:0]) + ROW_W'({wid_q[DIM_W-1:0], 1'b0});
	assign rlen = (dlen + ROW_W'(ROW_ALIGN - 1)) & ~ROW_W'(ROW_ALIGN - 1);

	assign in_data = (rbc_q <= dlm1_q);
	assign fin     = in_data && (lane_q == LANE_RED) && (row_q == hm1_q) &&
		(rbc_q == dlm1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		push     = 1'b0;
		err      = 1'b0;
		err_code = ST_PIXEL;
		rec      = '{status: ST_PIXEL, last: 1'b0, red: 8'd0, green: 8'd0, blue: 8'd0};
		if (accept) begin
			phase_d = eff_phase;
			case (eff_phase)
				PH_HEADER: begin
					if (eff_pos == POS_SIG0 && data_byte != SIG_B) begin
						err      = 1'b1;
						err_code = ST_BAD_SIG;
					end else if (eff_pos == POS_SIG1 && data_byte != SIG_M) begin
						err      = 1'b1;
						err_code = ST_BAD_SIG;
					end else if (eff_pos == POS_OFS3 &&
							{data_byte, ofs_q[23:0]} < 32'(MIN_OFFSET)) begin
						err      = 1'b1;
						err_code = ST_BAD_RANGE;
					end else if (eff_pos == POS_BPP1) begin
						if ({data_byte, bpp_lo_q} != BPP_24) begin
							err      = 1'b1;
							err_code = ST_BAD_DEPTH;
						end else if (size_bad) begin
							err      = 1'b1;
							err_code = ST_BAD_RANGE;
						end else begin
							phase_d = (ofs_q == 32'(MIN_OFFSET)) ? PH_PIXELS : PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					if (ofs_q == 32'd1) begin
						phase_d = PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (in_data && lane_q == LANE_RED) begin
						push      = 1'b1;
						rec.red   = data_byte;
						rec.green = green_q;
						rec.blue  = blue_q;
						rec.last  = fin;
						if (fin) begin
							phase_d = PH_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
			if (err) begin
				push       = 1'b1;
				rec.status = err_code;
				rec.last   = 1'b1;
				phase_d    = PH_IDLE;
			end
		end
	end

	// Position and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			rbc_q  <= '0;
			row_q  <= '0;
			lane_q <= LANE_BLUE;
		end else if (accept) begin
			if (eff_phase == PH_HEADER) begin
				pos_q <= eff_pos + POS_W'(1);
				if (eff_pos == POS_BPP1) begin
					rbc_q  <= '0;
					row_q  <= '0;
					lane_q <= LANE_BLUE;
				end
			end else if (eff_phase == PH_PIXELS && !fin) begin
				if (rbc_q == rlm1_q) begin
					rbc_q  <= '0;
					row_q  <= row_q + DIM_W'(1);
					lane_q <= LANE_BLUE;
				end else begin
					rbc_q <= rbc_q + ROW_W'(1);
					if (in_data) begin
						lane_q <= (lane_q == LANE_RED) ? LANE_BLUE : lane_q + 2'd1;
					end
				end
			end
		end
	end

	// Header fields, derived row geometry and the held colour bytes.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (eff_phase)
				PH_HEADER: begin
					if (eff_pos >= POS_OFS && eff_pos <= POS_OFS3) begin
						ofs_q[{cap_lane, 3'b000} +: 8] <= data_byte;
					end
					if (eff_pos >= POS_WID && eff_pos < POS_HGT) begin
						wid_q[{2'(eff_pos - POS_WID), 3'b000} +: 8] <= data_byte;
					end
					if (eff_pos >= POS_HGT && eff_pos < POS_HGT + POS_W'(4)) begin
						hgt_q[{2'(eff_pos - POS_HGT), 3'b000} +: 8] <= data_byte;
					end
					if (eff_pos == POS_BPP0) begin
						bpp_lo_q <= data_byte;
					end
					if (eff_pos == POS_BPP1) begin
						ofs_q  <= ofs_q - 32'(MIN_OFFSET);
						dlm1_q <= dlen - ROW_W'(1);
						rlm1_q <= rlen - ROW_W'(1);
						hm1_q  <= hgt_q[DIM_W-1:0] - DIM_W'(1);
					end
				end
				PH_SKIP: begin
					ofs_q <= ofs_q - 32'd1;
				end
				PH_PIXELS: begin
					if (in_data && lane_q == LANE_BLUE) begin
						blue_q <= data_byte;
					end
					if (in_data && lane_q == LANE_GREEN) begin
						green_q <= data_byte;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`ASSERT_NXT(a_err_to_idle, clk, arst_n, push && rec.status != ST_PIXEL, phase_q == PH_IDLE)
	`ASSERT_IMP(a_idle_quiet, clk, arst_n, accept && phase_q == PH_IDLE && !file_start, !push)

endmodule

// File: rtl/bmp24_back.sv
`include "bmp24_stream_to_rgb565_core_defines.svh"

module bmp24_back
	import bmp24_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  rec_t        q_rec,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic        valid_q, last_q;
	logic [15:0] pixel_q;
	logic [1:0]  status_q;

	// Refill the output register when it is empty or being drained.
	assign q_pop = !q_empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= !q_empty;
		end
	end

	// Error records carry zero colour bytes, so they pack to a zero pixel.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pixel_q  <= {q_rec.red[7:3], q_rec.green[7:2], q_rec.blue[7:3]};
			status_q <= q_rec.status;
			last_q   <= q_rec.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = pixel_q;
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

	`ASSERT_IMP(a_err_zero, clk, arst_n, m_tvalid && m_tuser != ST_PIXEL, m_tdata == 16'd0 && m_tlast)

endmodule

// File: rtl/bmp24_stream_to_rgb565_core.sv
// A result reaches the master side by way of the result queue and then the output register.
// Throughput: one byte per cycle sustained; a pixel result follows every third data byte.
// The parser only stalls when the four-entry-plus-output result queue is full.
// Reset (arst_n low, asynchronous): parser back to the header phase, queue emptied,
// no result valid; a new file may start on the first byte after reset.
module bmp24_stream_to_rgb565_core
	import bmp24_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte [7:0]
	input  logic        s_tuser,   // file_start [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // pixel [15:0]: red 15..11, green 10..5, blue 4..0
	output logic [1:0]  m_tuser,   // status [1:0]
	output logic        m_tlast
);

	// The front end parses the byte stream: it walks the header, checks the
	// signature, depth and geometry, skips to the pixel data and gathers each
	// blue, green, red triple. Every byte that completes a pixel, and every
	// error, becomes one record. A byte is taken on every transfer unless the
	// queue is full.
	//
	// The queue decouples the parser from the output. The back end packs each
	// record into RGB565 in its output register, which holds a result while
	// the downstream side stalls, without stopping the parser until the queue is full.

	localparam int REC_W = $bits(rec_t);

	rec_t             front_rec, q_rec;
	logic             push, pop, q_full, q_empty;
	logic [REC_W-1:0] q_dout;

	bmp24_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.data_byte (s_tdata),
		.file_start(s_tuser),
		.q_full    (q_full),
		.push      (push),
		.rec       (front_rec)
	);

	bmp24_queue #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (front_rec),
		.pop   (pop),
		.dout  (q_dout),
		.full  (q_full),
		.empty (q_empty)
	);

	assign q_rec = rec_t'(q_dout);

	bmp24_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rec   (q_rec),
		.q_pop   (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
